@@ rtl/core/westw_pkg.sv @@
// shared types and constants of the westwood congestion controller
package westw_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 120;
   localparam int OPCODE_W = 3;
   localparam int BW_W = 48;
   localparam int TIME_W = 40;
   localparam int DEN_W = 40;
   localparam int MUL_A_W = 24;
   localparam int MUL_B_W = 32;
   localparam int PROD_W = MUL_A_W + MUL_B_W;
   localparam int ACC_W = 66;

   localparam logic [15:0] ALPHA_Q16 = 16'd58982;
   localparam logic [15:0] ONE_MINUS_ALPHA_Q16 = 16'd6554;

   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENT_SIZE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_WINDOW = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PLUS_MODE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ON = 3'd4;

   localparam logic [OPCODE_W-1:0] OP_START = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_ACK = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_NEW_ACK = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_DUP_ACK = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_TIMEOUT = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_RTT = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_TICK = 3'd6;

   typedef enum logic [5:0] {
      C_NOP,
      C_LOAD,
      C_MUL_IWS,
      C_SET_START,
      C_DIV_CNT,
      C_CNT_FIX,
      C_SEG_ADD,
      C_MUL_NSEG,
      C_ACK_ERR,
      C_DIV_ACK,
      C_MUL_SSEG,
      C_TICK_ERR,
      C_DIV_TICK,
      C_SAMPLE,
      C_BW_RAW,
      C_F0,
      C_F1,
      C_F2,
      C_F3,
      C_F4,
      C_F5,
      C_REC_EXIT,
      C_ADD_SEG,
      C_MUL_SS,
      C_DIV_CA,
      C_ADD_CA,
      C_MUL_BWHI,
      C_MUL_BWLO,
      C_BW_T,
      C_DUP_ENTER,
      C_DUP_INFL,
      C_RTO,
      C_RTO_IDLE,
      C_RTT,
      C_OUT
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic ack_go;
      logic plus;
      logic filter;
      logic sampling;
      logic recovering;
      logic dup3;
      logic est_out;
      logic rtt_zero;
      logic dt_zero;
      logic cwnd_lt_thr;
      logic div_busy;
      logic out_free;
   } dp_stat_type;

endpackage

@@ rtl/core/westw_div.sv @@
// restoring divider, one quotient bit per cycle
module westw_div #(
   parameter int DW = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [DW-1:0]                  dividend,
   input  logic [westw_pkg::DEN_W-1:0]    divisor,
   output logic                           busy,
   output logic [DW-1:0]                  quotient
);
   localparam int VW = westw_pkg::DEN_W;
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] quot_ff;
   logic [VW-1:0] rem_ff;
   logic [VW-1:0] den_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic [VW:0]   rem_sh;
   logic          ge;
   logic [VW:0]   rem_sub;

   assign rem_sh = {rem_ff, quot_ff[DW-1]};
   assign ge = rem_sh >= {1'b0, den_ff};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff <= CW'(DW);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[DW-2:0], ge};
         rem_ff <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
      end
   end

   assign busy = busy_ff;
   assign quotient = quot_ff;
endmodule

@@ rtl/core/westw_ctrl.sv @@
// event sequencer of the westwood congestion controller
module westw_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  westw_pkg::dp_stat_type   stat,
   output westw_pkg::ctrl_cmd_type  cmd
);
   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_START_SET,
      S_CNT_WAIT,
      S_CNT_NEXT,
      S_ACK_DIV,
      S_TICK_DIV,
      S_RATE_WAIT,
      S_FILT0,
      S_F1,
      S_F2,
      S_F3,
      S_F4,
      S_F5,
      S_NEW_GROW,
      S_CA_DIV,
      S_CA_WAIT,
      S_BW_LO,
      S_BW_T,
      S_BW_APPLY,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   westw_pkg::dp_cmd_type op;

   always_comb begin
      state_in = state_ff;
      op = westw_pkg::C_NOP;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op = westw_pkg::C_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_OUT;
            case (stat.opcode)
               westw_pkg::OP_START: begin
                  op = westw_pkg::C_MUL_IWS;
                  state_in = S_START_SET;
               end
               westw_pkg::OP_ACK: begin
                  if (stat.ack_go) begin
                     op = westw_pkg::C_DIV_CNT;
                     state_in = S_CNT_WAIT;
                  end
               end
               westw_pkg::OP_NEW_ACK: begin
                  op = westw_pkg::C_REC_EXIT;
                  state_in = S_NEW_GROW;
               end
               westw_pkg::OP_DUP_ACK: begin
                  if (stat.dup3 && !stat.recovering) begin
                     op = westw_pkg::C_MUL_BWHI;
                     state_in = S_BW_LO;
                  end else if (stat.recovering) begin
                     op = westw_pkg::C_DUP_INFL;
                  end
               end
               westw_pkg::OP_TIMEOUT: begin
                  if (stat.est_out) begin
                     op = westw_pkg::C_MUL_BWHI;
                     state_in = S_BW_LO;
                  end else begin
                     op = westw_pkg::C_RTO_IDLE;
                  end
               end
               westw_pkg::OP_RTT: begin
                  op = westw_pkg::C_RTT;
               end
               westw_pkg::OP_TICK: begin
                  if (stat.plus && stat.sampling) begin
                     if (stat.rtt_zero) begin
                        op = westw_pkg::C_TICK_ERR;
                     end else begin
                        op = westw_pkg::C_MUL_SSEG;
                        state_in = S_TICK_DIV;
                     end
                  end
               end
               default: begin
                  op = westw_pkg::C_NOP;
               end
            endcase
         end
         S_START_SET: begin
            op = westw_pkg::C_SET_START;
            state_in = S_OUT;
         end
         S_CNT_WAIT: begin
            if (!stat.div_busy) begin
               op = westw_pkg::C_CNT_FIX;
               state_in = S_CNT_NEXT;
            end
         end
         S_CNT_NEXT: begin
            if (!stat.plus) begin
               op = westw_pkg::C_MUL_NSEG;
               state_in = S_ACK_DIV;
            end else begin
               op = westw_pkg::C_SEG_ADD;
               state_in = S_OUT;
            end
         end
         S_ACK_DIV: begin
            if (stat.dt_zero) begin
               op = westw_pkg::C_ACK_ERR;
               state_in = S_OUT;
            end else begin
               op = westw_pkg::C_DIV_ACK;
               state_in = S_RATE_WAIT;
            end
         end
         S_TICK_DIV: begin
            op = westw_pkg::C_DIV_TICK;
            state_in = S_RATE_WAIT;
         end
         S_RATE_WAIT: begin
            if (!stat.div_busy) begin
               op = westw_pkg::C_SAMPLE;
               state_in = S_FILT0;
            end
         end
         S_FILT0: begin
            if (stat.filter) begin
               op = westw_pkg::C_F0;
               state_in = S_F1;
            end else begin
               op = westw_pkg::C_BW_RAW;
               state_in = S_OUT;
            end
         end
         S_F1: begin
            op = westw_pkg::C_F1;
            state_in = S_F2;
         end
         S_F2: begin
            op = westw_pkg::C_F2;
            state_in = S_F3;
         end
         S_F3: begin
            op = westw_pkg::C_F3;
            state_in = S_F4;
         end
         S_F4: begin
            op = westw_pkg::C_F4;
            state_in = S_F5;
         end
         S_F5: begin
            op = westw_pkg::C_F5;
            state_in = S_OUT;
         end
         S_NEW_GROW: begin
            if (stat.cwnd_lt_thr) begin
               op = westw_pkg::C_ADD_SEG;
               state_in = S_OUT;
            end else begin
               op = westw_pkg::C_MUL_SS;
               state_in = S_CA_DIV;
            end
         end
         S_CA_DIV: begin
            op = westw_pkg::C_DIV_CA;
            state_in = S_CA_WAIT;
         end
         S_CA_WAIT: begin
            if (!stat.div_busy) begin
               op = westw_pkg::C_ADD_CA;
               state_in = S_OUT;
            end
         end
         S_BW_LO: begin
            op = westw_pkg::C_MUL_BWLO;
            state_in = S_BW_T;
         end
         S_BW_T: begin
            op = westw_pkg::C_BW_T;
            state_in = S_BW_APPLY;
         end
         S_BW_APPLY: begin
            op = (stat.opcode == westw_pkg::OP_DUP_ACK) ? westw_pkg::C_DUP_ENTER
                                                        : westw_pkg::C_RTO;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (stat.out_free) begin
               op = westw_pkg::C_OUT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign cmd.op = op;
endmodule

@@ rtl/core/westw_dp.sv @@
// datapath: registers, shared multiplier, divider and result register
module westw_dp #(
   parameter int BW_FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [westw_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [westw_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [westw_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [westw_pkg::OPCODE_W-1:0]        req_tuser,
   input  westw_pkg::ctrl_cmd_type               cmd,
   output westw_pkg::dp_stat_type                stat,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [westw_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   localparam int F = BW_FRAC_BITS;
   localparam int DW = westw_pkg::BW_W + F;
   localparam int BW_W = westw_pkg::BW_W;
   localparam int PW = westw_pkg::PROD_W;
   localparam int AW = westw_pkg::ACC_W;

   // configuration
   logic [15:0] seg_ff;
   logic [4:0]  iws_ff;
   logic [31:0] ithr_ff;
   logic        plus_ff;
   logic        filt_ff;

   // latched event
   logic [westw_pkg::OPCODE_W-1:0] opc_ff;
   logic [31:0] ack_ff;
   logic        ackf_ff;
   logic [7:0]  dup_ff;
   logic [westw_pkg::TIME_W-1:0] now_ff;
   logic [31:0] rtt_ff;
   logic        est_ff;
   logic        out_ff;

   // connection state
   logic [31:0] cwnd_ff;
   logic [31:0] thr_ff;
   logic        rec_ff;
   logic [BW_W-1:0] bw_ff;
   logic [BW_W-1:0] ls_ff;
   logic [BW_W-1:0] lf_ff;
   logic [31:0] rttmin_ff;
   logic [westw_pkg::TIME_W-1:0] last_ff;
   logic [31:0] prev_ff;
   logic [31:0] credit_ff;
   logic [31:0] segs_ff;
   logic        samp_ff;

   // working registers
   logic [PW-1:0]   prod_ff;
   logic [AW-1:0]   acc_ff;
   logic [BW_W-1:0] sample_ff;
   logic [31:0]     n_ff;
   logic [31:0]     t_ff;
   logic            f_retx_ff, f_send_ff, f_rto_ff, f_timer_ff, f_err_ff;

   logic                          rsp_valid_ff;
   logic [westw_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic [westw_pkg::MUL_A_W-1:0] mul_a;
   logic [westw_pkg::MUL_B_W-1:0] mul_b;
   logic                          mul_en;
   logic [DW-1:0]                 div_dividend;
   logic [westw_pkg::DEN_W-1:0]   div_divisor;
   logic                          div_start;
   logic                          div_busy;
   logic [DW-1:0]                 div_q;

   logic [BW_W:0]   avg_sum;
   logic [BW_W-1:0] avg;
   logic [31:0]     n0;
   logic [32:0]     credit_inc;
   logic [31:0]     ca_add;
   logic [AW-1:0]   acc_rnd;
   logic            hi_ovf;
   logic [63:0]     bwr_sum;
   logic [31:0]     bwr_t;
   logic [16:0]     two_seg;
   logic [BW_W-1:0] sample_sat;
   logic            out_free;

   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   westw_div #(.DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_q)
   );

   assign avg_sum = {1'b0, sample_ff} + {1'b0, ls_ff};
   assign avg = avg_sum[BW_W:1];
   assign n0 = (seg_ff == 16'd0) ? 32'd0 : div_q[31:0];
   assign credit_inc = {1'b0, credit_ff} + 33'd1;
   assign ca_add = (div_q[31:0] == 32'd0) ? 32'd1 : div_q[31:0];
   assign acc_rnd = acc_ff + AW'(32768);
   assign hi_ovf = |(acc_ff[PW-1:0] >> (8 + F));
   assign bwr_sum = ({8'd0, acc_ff[PW-1:0]} << (24 - F)) + ({8'd0, prod_ff} >> F);
   assign bwr_t = (hi_ovf || (|bwr_sum[63:32])) ? 32'hFFFF_FFFF : bwr_sum[31:0];
   assign two_seg = {seg_ff, 1'b0};
   assign sample_sat = (|div_q[DW-1:BW_W]) ? {BW_W{1'b1}} : div_q[BW_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      mul_en = 1'b1;
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         westw_pkg::C_MUL_IWS: begin
            mul_a = {8'd0, seg_ff};
            mul_b = {27'd0, iws_ff};
         end
         westw_pkg::C_MUL_NSEG: begin
            mul_a = {8'd0, seg_ff};
            mul_b = n_ff;
         end
         westw_pkg::C_MUL_SSEG: begin
            mul_a = {8'd0, seg_ff};
            mul_b = segs_ff;
         end
         westw_pkg::C_MUL_SS: begin
            mul_a = {8'd0, seg_ff};
            mul_b = {16'd0, seg_ff};
         end
         westw_pkg::C_MUL_BWHI: begin
            mul_a = bw_ff[47:24];
            mul_b = rttmin_ff;
         end
         westw_pkg::C_MUL_BWLO: begin
            mul_a = bw_ff[23:0];
            mul_b = rttmin_ff;
         end
         westw_pkg::C_F0: begin
            mul_a = lf_ff[47:24];
            mul_b = {16'd0, westw_pkg::ALPHA_Q16};
         end
         westw_pkg::C_F1: begin
            mul_a = lf_ff[23:0];
            mul_b = {16'd0, westw_pkg::ALPHA_Q16};
         end
         westw_pkg::C_F2: begin
            mul_a = avg[47:24];
            mul_b = {16'd0, westw_pkg::ONE_MINUS_ALPHA_Q16};
         end
         westw_pkg::C_F3: begin
            mul_a = avg[23:0];
            mul_b = {16'd0, westw_pkg::ONE_MINUS_ALPHA_Q16};
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      div_start = 1'b1;
      div_dividend = '0;
      div_divisor = '0;
      case (cmd.op)
         westw_pkg::C_DIV_CNT: begin
            div_dividend = DW'(ack_ff - prev_ff);
            div_divisor = {24'd0, seg_ff};
         end
         westw_pkg::C_DIV_ACK: begin
            div_dividend = {prod_ff[BW_W-1:0], {F{1'b0}}};
            div_divisor = now_ff - last_ff;
         end
         westw_pkg::C_DIV_TICK: begin
            div_dividend = {prod_ff[BW_W-1:0], {F{1'b0}}};
            div_divisor = {8'd0, rtt_ff};
         end
         westw_pkg::C_DIV_CA: begin
            div_dividend = DW'(prod_ff[31:0]);
            div_divisor = {8'd0, (cwnd_ff == 32'd0) ? 32'd1 : cwnd_ff};
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      case (cmd.op)
         westw_pkg::C_LOAD: begin
            opc_ff <= req_tuser;
            ack_ff <= req_tdata[31:0];
            ackf_ff <= req_tdata[32];
            dup_ff <= req_tdata[40:33];
            now_ff <= req_tdata[80:41];
            rtt_ff <= req_tdata[112:81];
            est_ff <= req_tdata[113];
            out_ff <= req_tdata[114];
         end
         westw_pkg::C_CNT_FIX: begin
            if (n0 == 32'd0) begin
               n_ff <= 32'd1;
            end else if (n0 != 32'd1 && credit_ff >= n0) begin
               n_ff <= 32'd1;
            end else if (n0 != 32'd1) begin
               n_ff <= n0 - credit_ff;
            end else begin
               n_ff <= 32'd1;
            end
         end
         westw_pkg::C_SAMPLE: sample_ff <= sample_sat;
         westw_pkg::C_F0: acc_ff <= '0;
         westw_pkg::C_F1: acc_ff <= acc_ff + {prod_ff[41:0], 24'd0};
         westw_pkg::C_F2: acc_ff <= acc_ff + {10'd0, prod_ff};
         westw_pkg::C_F3: acc_ff <= acc_ff + {prod_ff[41:0], 24'd0};
         westw_pkg::C_F4: acc_ff <= acc_ff + {10'd0, prod_ff};
         westw_pkg::C_MUL_BWLO: acc_ff <= {10'd0, prod_ff};
         westw_pkg::C_BW_T: t_ff <= bwr_t;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= 16'd536;
         iws_ff <= 5'd1;
         ithr_ff <= 32'd65535;
         plus_ff <= 1'b0;
         filt_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            westw_pkg::CSR_SEGMENT_SIZE: seg_ff <= csr_wdata[15:0];
            westw_pkg::CSR_INIT_WINDOW: iws_ff <= csr_wdata[4:0];
            westw_pkg::CSR_INIT_THRESHOLD: ithr_ff <= csr_wdata;
            westw_pkg::CSR_PLUS_MODE: plus_ff <= csr_wdata[0];
            westw_pkg::CSR_FILTER_ON: filt_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cwnd_ff <= '0;
         thr_ff <= 32'd65535;
         rec_ff <= 1'b0;
         bw_ff <= '0;
         ls_ff <= '0;
         lf_ff <= '0;
         rttmin_ff <= '0;
         last_ff <= '0;
         prev_ff <= '0;
         credit_ff <= '0;
         segs_ff <= '0;
         samp_ff <= 1'b0;
         f_retx_ff <= 1'b0;
         f_send_ff <= 1'b0;
         f_rto_ff <= 1'b0;
         f_timer_ff <= 1'b0;
         f_err_ff <= 1'b0;
      end else begin
         case (cmd.op)
            westw_pkg::C_LOAD: begin
               f_retx_ff <= 1'b0;
               f_send_ff <= 1'b0;
               f_rto_ff <= 1'b0;
               f_timer_ff <= 1'b0;
               f_err_ff <= 1'b0;
            end
            westw_pkg::C_SET_START: begin
               cwnd_ff <= prod_ff[31:0];
               thr_ff <= ithr_ff;
            end
            westw_pkg::C_CNT_FIX: begin
               prev_ff <= ack_ff;
               if (n0 == 32'd0) begin
                  credit_ff <= credit_inc[32] ? 32'hFFFF_FFFF : credit_inc[31:0];
               end else if (n0 != 32'd1 && credit_ff >= n0) begin
                  credit_ff <= credit_ff - n0;
               end else if (n0 != 32'd1) begin
                  credit_ff <= '0;
               end
            end
            westw_pkg::C_SEG_ADD: segs_ff <= sat_add32(segs_ff, n_ff);
            westw_pkg::C_ACK_ERR: begin
               f_err_ff <= 1'b1;
               last_ff <= now_ff;
            end
            westw_pkg::C_DIV_ACK: last_ff <= now_ff;
            westw_pkg::C_TICK_ERR: begin
               f_err_ff <= 1'b1;
               segs_ff <= '0;
               samp_ff <= 1'b0;
            end
            westw_pkg::C_DIV_TICK: begin
               segs_ff <= '0;
               samp_ff <= 1'b0;
            end
            westw_pkg::C_BW_RAW: bw_ff <= sample_ff;
            westw_pkg::C_F5: begin
               bw_ff <= acc_rnd[63:16];
               lf_ff <= acc_rnd[63:16];
               ls_ff <= sample_ff;
            end
            westw_pkg::C_REC_EXIT: begin
               if (rec_ff) begin
                  cwnd_ff <= thr_ff;
                  rec_ff <= 1'b0;
               end
            end
            westw_pkg::C_ADD_SEG: cwnd_ff <= sat_add32(cwnd_ff, {16'd0, seg_ff});
            westw_pkg::C_ADD_CA: cwnd_ff <= sat_add32(cwnd_ff, ca_add);
            westw_pkg::C_DUP_ENTER: begin
               thr_ff <= t_ff;
               if (cwnd_ff > t_ff) begin
                  cwnd_ff <= t_ff;
               end
               rec_ff <= 1'b1;
               f_retx_ff <= 1'b1;
            end
            westw_pkg::C_DUP_INFL: begin
               cwnd_ff <= sat_add32(cwnd_ff, {16'd0, seg_ff});
               f_send_ff <= 1'b1;
            end
            westw_pkg::C_RTO: begin
               thr_ff <= (t_ff > {15'd0, two_seg}) ? t_ff : {15'd0, two_seg};
               cwnd_ff <= {16'd0, seg_ff};
               rec_ff <= 1'b0;
               f_rto_ff <= 1'b1;
               f_retx_ff <= 1'b1;
            end
            westw_pkg::C_RTO_IDLE: rec_ff <= 1'b0;
            westw_pkg::C_RTT: begin
               if (rttmin_ff == 32'd0 || rtt_ff < rttmin_ff) begin
                  rttmin_ff <= rtt_ff;
               end
               if (plus_ff && rtt_ff != 32'd0 && est_ff && !samp_ff) begin
                  samp_ff <= 1'b1;
                  f_timer_ff <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == westw_pkg::C_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == westw_pkg::C_OUT) begin
         rsp_data_ff <= {2'd0, f_err_ff, f_timer_ff, f_rto_ff, f_send_ff, f_retx_ff,
                         rec_ff, bw_ff, thr_ff, cwnd_ff};
      end
   end

   assign stat.opcode = opc_ff;
   assign stat.ack_go = ackf_ff && (ack_ff >= prev_ff) && (!plus_ff || samp_ff);
   assign stat.plus = plus_ff;
   assign stat.filter = filt_ff;
   assign stat.sampling = samp_ff;
   assign stat.recovering = rec_ff;
   assign stat.dup3 = (dup_ff == 8'd3);
   assign stat.est_out = est_ff && out_ff;
   assign stat.rtt_zero = (rtt_ff == 32'd0);
   assign stat.dt_zero = (now_ff == last_ff);
   assign stat.cwnd_lt_thr = (cwnd_ff < thr_ff);
   assign stat.div_busy = div_busy;
   assign stat.out_free = out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
endmodule

@@ rtl/core/westwood_congestion_control.sv @@
// top level of the westwood congestion controller
// One event beat on req_ gives one status beat on rsp_. The event opcode
// travels in req_tuser; req_tdata carries ack number, ack flag, dup count,
// time, rtt sample and the connection flags. rsp_tdata carries window,
// threshold, bandwidth estimate, fast recovery and the request flags.
// The csr_ port writes one configuration register per cycle; the user must
// write it only while idle, and the block itself has no guard for this.
// Events are handled one at a time: req_tready is high only when the
// sequencer is idle. A new ack in congestion avoidance and an ack in
// per-ack sampling mode wait on the shared one-bit-per-cycle divider,
// which serves segment counting, the bandwidth sample and the window
// increment. A result beat waits in an output register, so the next event
// is taken and worked on while rsp_tready is low; it holds before its own
// result until the register frees. Reset sets the connection state and
// the flags to their initial values, loads the default configuration and
// leaves req_tready high the next cycle.
module westwood_congestion_control #(
   parameter int BW_FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [westw_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [westw_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // ack_number, ack_flag, dup_count, now_us, rtt_us, established, data_outstanding
   input  logic [westw_pkg::REQ_DATA_W-1:0]      req_tdata,
   // opcode
   input  logic [westw_pkg::OPCODE_W-1:0]        req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // congestion_window, slow_start_threshold, bandwidth_estimate, fast_recovery,
   // retransmit_now, send_pending, rto_backoff, start_timer, divide_error
   output logic [westw_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   localparam int RSP_FR_BIT = 112;
   localparam int RSP_SEND_BIT = 114;
   localparam int RSP_RTO_BIT = 115;

   westw_pkg::ctrl_cmd_type cmd;
   westw_pkg::dp_stat_type  stat;

   westw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   westw_dp #(.BW_FRAC_BITS(BW_FRAC_BITS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_one_event: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("new event accepted while one is in progress");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      stat.div_busy |-> (cmd.op != westw_pkg::C_DIV_CNT && cmd.op != westw_pkg::C_DIV_ACK
         && cmd.op != westw_pkg::C_DIV_TICK && cmd.op != westw_pkg::C_DIV_CA))
      else $error("divider restarted while busy");

   a_rto_no_rec: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[RSP_RTO_BIT]) |-> !rsp_tdata[RSP_FR_BIT])
      else $error("timeout left fast recovery set");

   a_send_in_rec: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[RSP_SEND_BIT]) |-> rsp_tdata[RSP_FR_BIT])
      else $error("window inflation outside fast recovery");
endmodule

@@ bench/tb.sv @@
// self-checking testbench for the westwood congestion controller
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 5000;
   localparam int HOLD_CYCLES = 600;

   typedef struct packed {
      logic [westw_pkg::OPCODE_W-1:0] opcode;
      logic [31:0] ack_number;
      logic        ack_flag;
      logic [7:0]  dup_count;
      logic [39:0] now_us;
      logic [31:0] rtt_us;
      logic        established;
      logic        outstanding;
   } cc_event_type;

   // highest bit first, so cwnd lands in the lowest bits
   typedef struct packed {
      logic        divide_error;
      logic        start_timer;
      logic        rto_backoff;
      logic        send_pending;
      logic        retransmit;
      logic        fast_recovery;
      logic [47:0] bw;
      logic [31:0] ssthresh;
      logic [31:0] cwnd;
   } cc_status_type;

   class westwood_scoreboard;
      bit [15:0] seg_size;
      bit [4:0]  init_win;
      bit [31:0] init_thr;
      bit        plus, filt;
      bit [31:0] cwnd, thr, rtt_min, prev_ack, credit, seg_count;
      bit        recovering, sampling;
      bit [63:0] bw, bw_last_sample, bw_last_filt;
      bit [39:0] last_time;
      cc_status_type pending_status[$];
      int errors;

      function void clear();
         seg_size = 536; init_win = 1; init_thr = 65535; plus = 0; filt = 1;
         cwnd = 0; thr = 65535; rtt_min = 0; prev_ack = 0; credit = 0; seg_count = 0;
         recovering = 0; sampling = 0;
         bw = 0; bw_last_sample = 0; bw_last_filt = 0; last_time = 0;
         pending_status.delete();
         errors = 0;
      endfunction

      function void write_csr(logic [westw_pkg::CSR_IDX_W-1:0] idx, logic [31:0] val);
         case (idx)
            westw_pkg::CSR_SEGMENT_SIZE: seg_size = val[15:0];
            westw_pkg::CSR_INIT_WINDOW: init_win = val[4:0];
            westw_pkg::CSR_INIT_THRESHOLD: init_thr = val;
            westw_pkg::CSR_PLUS_MODE: plus = val[0];
            westw_pkg::CSR_FILTER_ON: filt = val[0];
            default: ;
         endcase
      endfunction

      function bit [31:0] sat_add(bit [31:0] a, bit [63:0] b);
         bit [63:0] s;
         s = {32'd0, a} + b;
         return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
      endfunction

      function bit [63:0] rate(bit [63:0] num, bit [63:0] den);
         bit [63:0] q, r;
         q = num / den;
         r = num % den;
         if ((q >> 32) != 0) return 64'hFFFF_FFFF_FFFF;
         return (q << 16) + ((r << 16) / den);
      endfunction

      function bit [31:0] bw_rtt(bit [63:0] b, bit [31:0] rtt);
         bit [63:0] hi, lo, sum;
         hi = (b >> 24) * rtt;
         lo = (b & 64'hFF_FFFF) * rtt;
         if ((hi >> 24) != 0) return 32'hFFFF_FFFF;
         sum = (hi << 8) + (lo >> 16);
         return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      endfunction

      function void apply_sample(bit [63:0] sample);
         bit [63:0] avg, acc;
         if (filt) begin
            avg = (sample + bw_last_sample) >> 1;
            acc = 64'd58982 * bw_last_filt + 64'd6554 * avg;
            bw = (acc + 64'd32768) >> 16;
            bw_last_sample = sample;
            bw_last_filt = bw;
         end else begin
            bw = sample;
         end
      endfunction

      function bit [31:0] count_acked(bit [31:0] ack);
         bit [31:0] diff, n;
         diff = ack - prev_ack;
         n = (seg_size != 0) ? diff / seg_size : 0;
         if (n == 0) begin
            if (credit != 32'hFFFF_FFFF) credit++;
            n = 1;
         end
         if (n > 1) begin
            if (credit >= n) begin
               credit -= n;
               n = 1;
            end else begin
               n -= credit;
               credit = 0;
            end
         end
         prev_ack = ack;
         return n;
      endfunction

      function void note_event(cc_event_type ev);
         cc_status_type st;
         bit [31:0] n, t, two;
         bit [39:0] dt;
         bit [63:0] add;
         st = '0;
         case (ev.opcode)
            westw_pkg::OP_START: begin
               cwnd = init_win * seg_size;
               thr = init_thr;
            end
            westw_pkg::OP_ACK: begin
               if (ev.ack_flag && ev.ack_number >= prev_ack) begin
                  if (!plus) begin
                     n = count_acked(ev.ack_number);
                     dt = ev.now_us - last_time;
                     if (dt == 0) st.divide_error = 1;
                     else apply_sample(rate(64'(n) * 64'(seg_size), 64'(dt)));
                     last_time = ev.now_us;
                  end else if (sampling) begin
                     n = count_acked(ev.ack_number);
                     seg_count = sat_add(seg_count, 64'(n));
                  end
               end
            end
            westw_pkg::OP_NEW_ACK: begin
               if (recovering) begin
                  cwnd = thr;
                  recovering = 0;
               end
               if (cwnd < thr) begin
                  cwnd = sat_add(cwnd, 64'(seg_size));
               end else begin
                  add = (64'(seg_size) * seg_size) / ((cwnd != 0) ? cwnd : 1);
                  if (add < 1) add = 1;
                  cwnd = sat_add(cwnd, add);
               end
            end
            westw_pkg::OP_DUP_ACK: begin
               if (ev.dup_count == 3 && !recovering) begin
                  thr = bw_rtt(bw, rtt_min);
                  if (cwnd > thr) cwnd = thr;
                  recovering = 1;
                  st.retransmit = 1;
               end else if (recovering) begin
                  cwnd = sat_add(cwnd, 64'(seg_size));
                  st.send_pending = 1;
               end
            end
            westw_pkg::OP_TIMEOUT: begin
               recovering = 0;
               if (ev.established && ev.outstanding) begin
                  t = bw_rtt(bw, rtt_min);
                  two = 2 * seg_size;
                  thr = (t > two) ? t : two;
                  cwnd = seg_size;
                  st.rto_backoff = 1;
                  st.retransmit = 1;
               end
            end
            westw_pkg::OP_RTT: begin
               if (rtt_min == 0 || ev.rtt_us < rtt_min) rtt_min = ev.rtt_us;
               if (plus && ev.rtt_us != 0 && ev.established && !sampling) begin
                  sampling = 1;
                  st.start_timer = 1;
               end
            end
            westw_pkg::OP_TICK: begin
               if (plus && sampling) begin
                  if (ev.rtt_us == 0) st.divide_error = 1;
                  else apply_sample(rate(64'(seg_count) * 64'(seg_size), 64'(ev.rtt_us)));
                  seg_count = 0;
                  sampling = 0;
               end
            end
            default: ;
         endcase
         st.cwnd = cwnd;
         st.ssthresh = thr;
         st.bw = bw[47:0];
         st.fast_recovery = recovering;
         pending_status.push_back(st);
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_status(cc_status_type got);
         cc_status_type exp_st;
         if (pending_status.size() == 0) begin
            report("status beat with nothing expected");
            return;
         end
         exp_st = pending_status.pop_front();
         if (got.cwnd !== exp_st.cwnd)
            report($sformatf("cwnd %0d, want %0d", got.cwnd, exp_st.cwnd));
         if (got.ssthresh !== exp_st.ssthresh)
            report($sformatf("ssthresh %0d, want %0d", got.ssthresh, exp_st.ssthresh));
         if (got.bw !== exp_st.bw)
            report($sformatf("bandwidth %h, want %h", got.bw, exp_st.bw));
         if (got.fast_recovery !== exp_st.fast_recovery)
            report($sformatf("fast_recovery %b, want %b", got.fast_recovery,
                             exp_st.fast_recovery));
         if (got.retransmit !== exp_st.retransmit)
            report($sformatf("retransmit %b, want %b", got.retransmit, exp_st.retransmit));
         if (got.send_pending !== exp_st.send_pending)
            report($sformatf("send_pending %b, want %b", got.send_pending,
                             exp_st.send_pending));
         if (got.rto_backoff !== exp_st.rto_backoff)
            report($sformatf("rto_backoff %b, want %b", got.rto_backoff, exp_st.rto_backoff));
         if (got.start_timer !== exp_st.start_timer)
            report($sformatf("start_timer %b, want %b", got.start_timer, exp_st.start_timer));
         if (got.divide_error !== exp_st.divide_error)
            report($sformatf("divide_error %b, want %b", got.divide_error,
                             exp_st.divide_error));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [westw_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [westw_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_tvalid = 0;
   logic req_tready;
   logic [westw_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [westw_pkg::OPCODE_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [westw_pkg::RSP_DATA_W-1:0] rsp_tdata;

   westwood_congestion_control dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   westwood_scoreboard sb;
   int idle_cycles = 0;
   bit hold_request = 0;
   bit [31:0] ack_seq;
   bit [39:0] now_seq;
   bit [7:0] dup_seq;
   bit sender_burst = 0;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("westwood_congestion_control verification failed");
            $finish;
         end
      end
   end

   // result side
   initial begin : receiver
      int w;
      bit burst;
      cc_status_type got;
      burst = 0;
      @(negedge clock);
      forever begin
         if ($urandom_range(40, 0) == 0) burst = !burst;
         if (hold_request) begin
            hold_request = 0;
            rsp_tready = 0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         w = burst ? 0 : $urandom_range(15, 0);
         if (w > 0) begin
            rsp_tready = 0;
            repeat (w) @(negedge clock);
         end
         rsp_tready = 1;
         do begin
            @(posedge clock);
         end while (!rsp_tvalid);
         got = rsp_tdata[117:0];
         sb.check_status(got);
         @(negedge clock);
      end
   end

   task send_event(cc_event_type ev);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(15, 0);
      if (gap > 0) begin
         req_tvalid = 0;
         repeat (gap) @(negedge clock);
      end
      req_tuser = ev.opcode;
      req_tdata = {5'd0, ev.outstanding, ev.established, ev.rtt_us, ev.now_us,
                   ev.dup_count, ev.ack_flag, ev.ack_number};
      req_tvalid = 1;
      do begin
         @(posedge clock);
      end while (!req_tready);
      sb.note_event(ev);
      @(negedge clock);
   endtask

   task drain();
      req_tvalid = 0;
      while (sb.pending_status.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task write_reg(logic [westw_pkg::CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = val;
      sb.write_csr(idx, val);
      @(negedge clock);
      csr_we = 0;
   endtask

   task load_config(bit [15:0] seg, bit [4:0] iw, bit [31:0] thr, bit pl, bit fl);
      write_reg(westw_pkg::CSR_SEGMENT_SIZE, {16'd0, seg});
      write_reg(westw_pkg::CSR_INIT_WINDOW, {27'd0, iw});
      write_reg(westw_pkg::CSR_INIT_THRESHOLD, thr);
      write_reg(westw_pkg::CSR_PLUS_MODE, {31'd0, pl});
      write_reg(westw_pkg::CSR_FILTER_ON, {31'd0, fl});
   endtask

   function cc_event_type make_event(logic [2:0] op, logic [31:0] ack, logic fl,
                                     logic [7:0] dc, logic [39:0] now, logic [31:0] rtt,
                                     logic est, logic outs);
      cc_event_type ev;
      ev.opcode = op; ev.ack_number = ack; ev.ack_flag = fl; ev.dup_count = dc;
      ev.now_us = now; ev.rtt_us = rtt; ev.established = est; ev.outstanding = outs;
      return ev;
   endfunction

   function cc_event_type noise_event();
      return make_event(3'($urandom_range(7, 0)), $urandom, 1'($urandom_range(1, 0)),
                        8'($urandom), {8'($urandom_range(255, 0)), $urandom}, $urandom,
                        1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
   endfunction

   function bit [31:0] pick_rtt();
      int r;
      r = $urandom_range(19, 0);
      if (r == 0) return 0;
      if (r == 1) return $urandom;
      return $urandom_range(5000, 1);
   endfunction

   function cc_event_type flow_event();
      int r;
      bit [31:0] seg;
      seg = (sb.seg_size != 0) ? sb.seg_size : 1;
      r = $urandom_range(99, 0);
      if (r < 90) now_seq += ($urandom_range(7, 0) == 0) ? 0 : $urandom_range(3000, 1);
      if (r < 35) begin
         if ($urandom_range(15, 0) == 0) ack_seq += $urandom;
         else ack_seq += seg * $urandom_range(4, 0);
         return make_event(westw_pkg::OP_ACK, ack_seq, 1, dup_seq, now_seq, pick_rtt(), 1, 1);
      end
      if (r < 55) begin
         dup_seq = 0;
         return make_event(westw_pkg::OP_NEW_ACK, ack_seq, 1, 0, now_seq, pick_rtt(), 1, 1);
      end
      if (r < 70) begin
         dup_seq = ($urandom_range(3, 0) == 0) ? 8'd3 : dup_seq + 8'd1;
         return make_event(westw_pkg::OP_DUP_ACK, ack_seq, 1, dup_seq, now_seq, pick_rtt(),
                           1, 1);
      end
      if (r < 80)
         return make_event(westw_pkg::OP_RTT, ack_seq, 1, 0, now_seq, pick_rtt(),
                           $urandom_range(7, 0) != 0, 1);
      if (r < 88)
         return make_event(westw_pkg::OP_TICK, ack_seq, 1, 0, now_seq, pick_rtt(), 1, 1);
      if (r < 93)
         return make_event(westw_pkg::OP_TIMEOUT, ack_seq, 1, 0, now_seq, pick_rtt(),
                           $urandom_range(3, 0) != 0, $urandom_range(3, 0) != 0);
      if (r < 95) begin
         ack_seq = $urandom_range(1000, 0);
         return make_event(westw_pkg::OP_START, ack_seq, 1, 0, now_seq, 0, 1, 1);
      end
      return noise_event();
   endfunction

   task run_random(int count, bit do_hold);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(50, 0) == 0) sender_burst = !sender_burst;
         if (do_hold && i == count / 2) begin
            hold_request = 1;
            sender_burst = 1;
         end
         send_event(flow_event());
      end
      sender_burst = 0;
      drain();
   endtask

   initial begin : main
      sb = new;
      sb.clear();
      ack_seq = 0; now_seq = 0; dup_seq = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed corners at reset settings
      send_event(make_event(westw_pkg::OP_START, 0, 0, 0, 0, 0, 0, 0));
      send_event(make_event(westw_pkg::OP_ACK, 32'hFFFF_FFFF, 0, 0, 40'h12, 0, 1, 1));
      send_event(make_event(westw_pkg::OP_ACK, 5000, 1, 0, 0, 0, 1, 1));
      send_event(make_event(westw_pkg::OP_ACK, 5536, 1, 0, 40'h100, 0, 1, 1));
      send_event(make_event(westw_pkg::OP_ACK, 100, 1, 0, 40'h200, 0, 1, 1));
      send_event(make_event(westw_pkg::OP_ACK, 5600, 1, 0, 40'h300, 0, 1, 1));
      send_event(make_event(westw_pkg::OP_ACK, 32'hFFFF_FFFF, 1, 8'hFF, 40'hFF_FFFF_FFFF, 0,
                            1, 1));
      send_event(make_event(westw_pkg::OP_RTT, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, 1));
      send_event(make_event(westw_pkg::OP_RTT, 0, 0, 0, 0, 0, 1, 1));
      send_event(make_event(westw_pkg::OP_RTT, 0, 0, 0, 0, 1200, 1, 1));
      send_event(make_event(westw_pkg::OP_NEW_ACK, 0, 0, 0, 0, 0, 0, 0));
      send_event(make_event(westw_pkg::OP_DUP_ACK, 0, 0, 1, 0, 0, 0, 0));
      send_event(make_event(westw_pkg::OP_DUP_ACK, 0, 0, 3, 0, 0, 0, 0));
      send_event(make_event(westw_pkg::OP_DUP_ACK, 0, 0, 4, 0, 0, 0, 0));
      send_event(make_event(westw_pkg::OP_NEW_ACK, 0, 0, 0, 0, 0, 0, 0));
      send_event(make_event(westw_pkg::OP_TICK, 0, 0, 0, 0, 0, 1, 1));
      send_event(make_event(westw_pkg::OP_TIMEOUT, 0, 0, 0, 0, 0, 0, 1));
      send_event(make_event(westw_pkg::OP_TIMEOUT, 0, 0, 0, 0, 0, 1, 1));
      send_event(make_event(3'd7, 32'hFFFF_FFFF, 1, 8'hFF, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF,
                            1, 1));
      drain();

      load_config(16'd1, 5'd16, 32'd0, 1'b0, 1'b0);
      send_event(make_event(westw_pkg::OP_START, 0, 0, 0, 0, 0, 0, 0));
      send_event(make_event(westw_pkg::OP_NEW_ACK, 0, 0, 0, 0, 0, 0, 0));
      ack_seq = 0; now_seq = 40'hFF_FFFF_F000;
      run_random(250, 0);

      load_config(16'hFFFF, 5'd16, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_event(make_event(westw_pkg::OP_START, 0, 0, 0, 0, 0, 0, 0));
      send_event(make_event(westw_pkg::OP_RTT, 0, 0, 0, 0, 800, 1, 1));
      send_event(make_event(westw_pkg::OP_ACK, 32'hFFFF_0000, 1, 0, 0, 0, 1, 1));
      send_event(make_event(westw_pkg::OP_TICK, 0, 0, 0, 0, 0, 1, 1));
      send_event(make_event(westw_pkg::OP_RTT, 0, 0, 0, 0, 800, 1, 1));
      send_event(make_event(westw_pkg::OP_TICK, 0, 0, 0, 0, 1, 1, 1));
      run_random(300, 1);

      load_config(16'd0, 5'd1, 32'd1000, 1'b1, 1'b0);
      send_event(make_event(westw_pkg::OP_START, 0, 0, 0, 0, 0, 0, 0));
      run_random(150, 0);
      load_config(16'd0, 5'd3, 32'd1000, 1'b0, 1'b1);
      run_random(100, 0);

      load_config(16'd1460, 5'd10, $urandom, 1'b1, 1'b1);
      run_random(300, 0);
      load_config(16'd536, 5'd1, 32'd65535, 1'b0, 1'b1);
      run_random(300, 0);
      load_config(16'($urandom_range(65535, 1)), 5'($urandom_range(16, 1)), $urandom,
                  1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
      run_random(350, 0);

      drain();
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending_status.size() == 0) begin
         $display("westwood_congestion_control verification clean");
      end else begin
         $display("westwood_congestion_control verification failed");
      end
      $finish;
   end
endmodule
